// ----- design/i2c_master_transaction_sequencer_defines.svh -----
// Assertion macros shared by the sequencer checker.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH

// Assert a property on every rising clock edge outside reset.
`define MTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/i2c_mts_pkg.sv -----
// Types and codes of the I2C master transaction sequencer.
package i2c_mts_pkg;

  // Input operation codes
  typedef enum logic [3:0] {
    OP_LOAD_BYTE  = 4'd0,
    OP_PLAIN_READ = 4'd1,
    OP_REG_WRITE  = 4'd2,
    OP_REG_READ   = 4'd3,
    OP_START_SENT = 4'd4,
    OP_ADDR_SENT  = 4'd5,
    OP_BYTE_DONE  = 4'd6,
    OP_BYTE_RECV  = 4'd7,
    OP_BUS_ERROR  = 4'd8
  } op_e;

  // Transaction phase
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_START_W = 3'd1,
    PH_START_R = 3'd2,
    PH_ADDRESS = 3'd3,
    PH_READING = 3'd4
  } phase_e;

  // ACK control codes
  typedef enum logic [1:0] {
    ACK_KEEP    = 2'd0,
    ACK_ENABLE  = 2'd1,
    ACK_DISABLE = 2'd2
  } ack_e;

  localparam int unsigned LenW  = 9;
  localparam int unsigned ByteW = 8;

endpackage

// ----- design/i2c_mts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module i2c_mts_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/i2c_master_transaction_sequencer.sv -----
// I2C master transaction sequencer: turns commands and bus events into bus actions.
// Takes one word per clock cycle and answers each with exactly one result word, shown
// in the cycle after acceptance and held until taken; a stalled result stalls the input.
// Write bytes are loaded into the buffer store beforehand with load-byte words; the
// store's single read port is read in the cycle a byte-done word is accepted, so a
// loaded byte may be sent by the very next word. Positions at or beyond BUF_DEPTH are
// not stored and send zero. A new command abandons the running transaction silently.
module i2c_master_transaction_sequencer
  import i2c_mts_pkg::*;
#(
  parameter int BUF_DEPTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [3:0]       operation_i,
  input  logic [7:0]       slave_address_i,
  input  logic [7:0]       register_address_i,
  input  logic [LenW-1:0]  transfer_length_i,
  input  logic [7:0]       buffer_index_i,
  input  logic [7:0]       data_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             issue_start_o,
  output logic             issue_address_o,
  output logic             address_for_read_o,
  output logic             issue_byte_o,
  output logic [7:0]       bus_byte_o,
  output logic             issue_stop_o,
  output logic [1:0]       ack_control_o,
  output logic             finished_o,
  output logic             success_o,
  output logic [2:0]       phase_o,
  output logic [LenW-1:0]  byte_count_o
);

  localparam int AddrW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  // Transaction registers
  phase_e               phase_q, phase_d;
  logic                 is_read_q, is_read_d;
  logic [ByteW-1:0]     target_q, target_d;
  logic [ByteW-1:0]     register_q, register_d;
  logic [LenW-1:0]      total_q, total_d;
  logic [LenW-1:0]      pos_q, pos_d;

  // Result registers
  logic                 out_valid_q;
  logic                 start_q, start_d;
  logic                 addr_q, addr_d;
  logic                 addr_rd_q, addr_rd_d;
  logic                 ib_q, ib_d;
  logic [ByteW-1:0]     bb_q, bb_d;
  logic                 sel_mem_q, sel_mem_d;
  logic                 stop_q, stop_d;
  ack_e                 ack_q, ack_d;
  logic                 fin_q, fin_d;
  logic                 ok_q, ok_d;
  phase_e               ph_out_q;
  logic [LenW-1:0]      cnt_out_q;

  // Store port signals
  logic                 accept;
  op_e                  op;
  logic                 pos_in_range;
  logic                 idx_in_range;
  logic                 we;
  logic [AddrW-1:0]     waddr;
  logic                 re;
  logic [ByteW-1:0]     rdata;
  logic [LenW-1:0]      pos_inc;
  logic                 send_byte;

  assign in_ready_o   = !out_valid_q || out_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign op           = op_e'(operation_i);
  assign pos_in_range = 32'(pos_q) < BUF_DEPTH;
  assign idx_in_range = 32'(buffer_index_i) < BUF_DEPTH;
  assign pos_inc      = pos_q + LenW'(1);
  assign send_byte    = (phase_q == PH_ADDRESS) && !is_read_q && (pos_q < total_q);

  // Next transaction state
  always_comb begin
    phase_d    = phase_q;
    is_read_d  = is_read_q;
    target_d   = target_q;
    register_d = register_q;
    total_d    = total_q;
    pos_d      = pos_q;
    unique case (op)
      OP_PLAIN_READ, OP_REG_WRITE, OP_REG_READ: begin
        phase_d    = (op == OP_PLAIN_READ) ? PH_START_R : PH_START_W;
        is_read_d  = (op != OP_REG_WRITE);
        target_d   = slave_address_i;
        register_d = register_address_i;
        total_d    = transfer_length_i;
        pos_d      = '0;
      end
      OP_START_SENT: begin
        if (phase_q == PH_START_W) begin
          phase_d = PH_ADDRESS;
        end else if (phase_q == PH_START_R) begin
          phase_d = PH_READING;
        end
      end
      OP_BYTE_DONE: begin
        if (phase_q == PH_ADDRESS) begin
          if (is_read_q) begin
            phase_d = PH_START_R;
          end else begin
            if (send_byte) begin
              pos_d = pos_inc;
            end
            if (pos_d >= total_q) begin
              phase_d = PH_IDLE;
            end
          end
        end
      end
      OP_BYTE_RECV: begin
        if (phase_q == PH_READING) begin
          pos_d = pos_inc;
          if (pos_inc >= total_q) begin
            phase_d = PH_IDLE;
          end
        end
      end
      OP_BUS_ERROR: phase_d = PH_IDLE;
      default: ;
    endcase
  end

  // Bus actions for the accepted word
  always_comb begin
    start_d   = 1'b0;
    addr_d    = 1'b0;
    addr_rd_d = 1'b0;
    ib_d      = 1'b0;
    bb_d      = '0;
    sel_mem_d = 1'b0;
    stop_d    = 1'b0;
    ack_d     = ACK_KEEP;
    fin_d     = 1'b0;
    ok_d      = 1'b0;
    unique case (op)
      OP_PLAIN_READ, OP_REG_WRITE, OP_REG_READ: start_d = 1'b1;
      OP_START_SENT: begin
        if (phase_q == PH_START_W) begin
          addr_d = 1'b1;
          bb_d   = target_q;
        end else if (phase_q == PH_START_R) begin
          addr_d    = 1'b1;
          addr_rd_d = 1'b1;
          bb_d      = target_q;
          ack_d     = ACK_ENABLE;
        end
      end
      OP_ADDR_SENT: begin
        if (phase_q == PH_ADDRESS) begin
          ib_d = 1'b1;
          bb_d = register_q;
        end else if (phase_q == PH_READING && total_q == LenW'(1)) begin
          ack_d = ACK_DISABLE;
        end
      end
      OP_BYTE_DONE: begin
        if (phase_q == PH_ADDRESS) begin
          if (is_read_q) begin
            start_d = 1'b1;
          end else begin
            ib_d      = send_byte;
            sel_mem_d = send_byte && pos_in_range;
            if (pos_d >= total_q) begin
              stop_d = 1'b1;
              fin_d  = 1'b1;
              ok_d   = 1'b1;
            end
          end
        end
      end
      OP_BYTE_RECV: begin
        if (phase_q == PH_READING) begin
          if (total_q != '0 && pos_inc == total_q - LenW'(1)) begin
            ack_d = ACK_DISABLE;
          end
          if (pos_inc >= total_q) begin
            stop_d = 1'b1;
            fin_d  = 1'b1;
            ok_d   = 1'b1;
          end
        end
      end
      OP_BUS_ERROR: fin_d = 1'b1;
      default: ;
    endcase
  end

  // Store access: load and received bytes write, byte done reads
  assign we    = accept && ((op == OP_LOAD_BYTE && idx_in_range) ||
                            (op == OP_BYTE_RECV && phase_q == PH_READING && pos_in_range));
  assign waddr = (op == OP_LOAD_BYTE) ? AddrW'(buffer_index_i) : AddrW'(pos_q);
  assign re    = accept && (op == OP_BYTE_DONE);

  i2c_mts_ram #(
    .Width (ByteW),
    .Depth (BUF_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (data_byte_i),
    .re_i    (re),
    .raddr_i (AddrW'(pos_q)),
    .rdata_o (rdata)
  );

  // Update transaction state on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      is_read_q  <= 1'b0;
      target_q   <= '0;
      register_q <= '0;
      total_q    <= '0;
      pos_q      <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      is_read_q  <= is_read_d;
      target_q   <= target_d;
      register_q <= register_d;
      total_q    <= total_d;
      pos_q      <= pos_d;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      start_q   <= start_d;
      addr_q    <= addr_d;
      addr_rd_q <= addr_rd_d;
      ib_q      <= ib_d;
      bb_q      <= bb_d;
      sel_mem_q <= sel_mem_d;
      stop_q    <= stop_d;
      ack_q     <= ack_d;
      fin_q     <= fin_d;
      ok_q      <= ok_d;
      ph_out_q  <= phase_d;
      cnt_out_q <= pos_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign issue_start_o      = start_q;
  assign issue_address_o    = addr_q;
  assign address_for_read_o = addr_rd_q;
  assign issue_byte_o       = ib_q;
  assign bus_byte_o         = sel_mem_q ? rdata : bb_q;
  assign issue_stop_o       = stop_q;
  assign ack_control_o      = ack_q;
  assign finished_o         = fin_q;
  assign success_o          = ok_q;
  assign phase_o            = ph_out_q;
  assign byte_count_o       = cnt_out_q;

endmodule

// ----- design/i2c_mts_checker.sv -----
// Port-level checks of the I2C master transaction sequencer.
`include "i2c_master_transaction_sequencer_defines.svh"

module i2c_mts_checker
  import i2c_mts_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [3:0]       operation_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic             issue_address_o,
  input logic [7:0]       bus_byte_o,
  input logic             finished_o,
  input logic             success_o,
  input logic [2:0]       phase_o
);

  // Stalled result word keeps its byte
  `MTS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(bus_byte_o), "stalled result word changed")

  // A finished transaction leaves the sequencer idle
  `MTS_ASSERT(a_fin_idle, !(out_valid_o && finished_o) || phase_o == PH_IDLE, "finished but not idle")

  // A bus error word is answered with a failed finish
  `MTS_ASSERT_NEXT(a_err_fail, in_valid_i && in_ready_o && operation_i == OP_BUS_ERROR, out_valid_o && finished_o && !success_o, "bus error not reported as failure")

  // An address goes out only into the address or reading phase
  `MTS_ASSERT(a_addr_phase, !(out_valid_o && issue_address_o) || phase_o == PH_ADDRESS || phase_o == PH_READING, "address issued in wrong phase")

endmodule

bind i2c_master_transaction_sequencer i2c_mts_checker u_i2c_mts_checker (.*);
